// ===== rtl/core/vmwd_pkg.sv =====
// ============================================================================
// vmwd_pkg
// Shared types and constants of the video-memory write decoder: opcodes,
// sequencer states, memory geometry and the request bundle that passes from
// the address decoder to the memory block.
// ============================================================================
package vmwd_pkg;

    // Memory geometry
    localparam int PAT_IDX_W  = 12;  // {tile, pixel row}: one plane byte per row
    localparam int NAME_IDX_W = 11;  // {table row, table column}
    localparam int ATTR_IDX_W = 7;   // {table, block row, block column}
    localparam int PAL_IDX_W  = 5;
    localparam int PAL_DEPTH  = 32;
    localparam int CLR_W      = 12;  // clearing pass covers the largest store

    // Palette constants
    localparam logic [5:0] PAL_RESET    = 6'h0F;
    localparam logic [5:0] PAL_BLACK    = 6'h0F;
    localparam logic [5:0] PAL_BG_BLACK = 6'h0D;

    // Table geometry
    localparam logic [4:0] TBL_ROWS = 5'd30;

    // Address step sizes
    localparam logic [15:0] STEP_COL = 16'd1;
    localparam logic [15:0] STEP_ROW = 16'd32;

    typedef enum logic [2:0] {
        OP_LATCH        = 3'd0,
        OP_WRITE_STEP1  = 3'd1,
        OP_WRITE_STEP32 = 3'd2,
        OP_READ_PIXEL   = 3'd3,
        OP_READ_NAME    = 3'd4,
        OP_READ_ATTR    = 3'd5,
        OP_READ_PAL     = 3'd6,
        OP_NOP          = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        RD_NONE  = 3'd0,
        RD_PIXEL = 3'd1,
        RD_NAME  = 3'd2,
        RD_ATTR  = 3'd3,
        RD_PAL   = 3'd4
    } rd_kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    // Access request from the decoder
    typedef struct packed {
        logic                   pat0_we;
        logic                   pat1_we;
        logic                   name_we;
        logic                   attr_we;
        logic                   pal_we;
        logic [PAT_IDX_W-1:0]   pat_idx;
        logic [NAME_IDX_W-1:0]  name_idx;
        logic [ATTR_IDX_W-1:0]  attr_idx;
        logic [PAL_IDX_W-1:0]   pal_idx;
        logic [7:0]             wdata;
        rd_kind_t               rd_kind;
        logic [2:0]             pix_col;
        logic [1:0]             attr_quad;
    } mem_req_t;

    // Control from the sequencer
    typedef struct packed {
        logic             clear;
        logic [CLR_W-1:0] clr_idx;
        logic             exec;
    } mem_ctl_t;

endpackage

// ===== rtl/core/video_memory_write_decoder.sv =====
// ============================================================================
// video_memory_write_decoder
// Video-memory write port of a tile display processor: address latch,
// decoded writes with address stepping, and read-back of stored entries.
// ============================================================================
// Each beat is taken in the idle state, then an execute state in which the
// shared decoder drives a single registered access of the video stores and
// the address register steps, then a result state that presents the result
// until it is taken; the block takes no new beat until the result has gone.
// After reset a clearing pass zeroes the pattern, name and attribute stores,
// one row a cycle, with s_ready low. Pattern memory is held as two 4096 x 8
// bitplanes, so a pattern write is a plain byte write; attribute bytes are
// stored as written and expanded into 2-bit entries on read.
module video_memory_write_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_data,
    input  logic [8:0]  s_read_tile,
    input  logic [4:0]  s_read_row,
    input  logic [5:0]  s_read_col,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [15:0] m_address_now
);

    vmwd_pkg::op_t      op;
    logic [7:0]         data;
    logic [8:0]         read_tile;
    logic [4:0]         read_row;
    logic [5:0]         read_col;
    vmwd_pkg::mem_ctl_t ctl;
    vmwd_pkg::mem_req_t req;

    vmwd_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_address     (s_address),
        .s_data        (s_data),
        .s_read_tile   (s_read_tile),
        .s_read_row    (s_read_row),
        .s_read_col    (s_read_col),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_address_now (m_address_now),
        .op            (op),
        .data          (data),
        .read_tile     (read_tile),
        .read_row      (read_row),
        .read_col      (read_col),
        .ctl           (ctl)
    );

    vmwd_decode u_decode (
        .op         (op),
        .video_addr (m_address_now),
        .data       (data),
        .read_tile  (read_tile),
        .read_row   (read_row),
        .read_col   (read_col),
        .req        (req)
    );

    vmwd_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .req     (req),
        .rd_data (m_read_data)
    );

endmodule

// ===== rtl/core/vmwd_decode.sv =====
// ============================================================================
// vmwd_decode
// Address decoder shared by all opcodes: turns the video address (writes) or
// the read coordinates (reads) into one memory access request.
// ============================================================================
module vmwd_decode (
    input  vmwd_pkg::op_t      op,
    input  logic [15:0]        video_addr,
    input  logic [7:0]         data,
    input  logic [8:0]         read_tile,
    input  logic [4:0]         read_row,
    input  logic [5:0]         read_col,
    output vmwd_pkg::mem_req_t req
);

    logic is_write;
    logic is_pal;
    logic is_pat;
    logic is_name;

    // Region decode: bit 13 low: pattern, 0x3Fxx palette, 0x3xxx mirrors tables
    assign is_write = (op == vmwd_pkg::OP_WRITE_STEP1) || (op == vmwd_pkg::OP_WRITE_STEP32);
    assign is_pal   = (video_addr[13:8] == 6'h3F);
    assign is_pat   = !video_addr[13];
    assign is_name  = (video_addr[9:5] < vmwd_pkg::TBL_ROWS);

    always_comb begin
        req           = '0;
        req.wdata     = data;
        req.rd_kind   = vmwd_pkg::RD_NONE;
        req.pix_col   = read_col[2:0];
        req.attr_quad = {read_row[1], read_col[1]};
        if (is_write) begin
            // Write form: index from the video address
            req.pat_idx  = {video_addr[12:4], video_addr[2:0]};
            req.name_idx = {video_addr[9:5], video_addr[10], video_addr[4:0]};
            req.attr_idx = {video_addr[10], video_addr[5:0]};
            req.pal_idx  = video_addr[4:0];
            if (is_pat) begin
                req.pat0_we = !video_addr[3];
                req.pat1_we = video_addr[3];
            end else if (is_pal) begin
                req.pal_we = 1'b1;
            end else if (is_name) begin
                req.name_we = 1'b1;
            end else begin
                req.attr_we = 1'b1;
            end
        end else begin
            // Read form: index from the read coordinates
            req.pat_idx  = {read_tile, read_row[2:0]};
            req.name_idx = {read_row, read_col};
            req.attr_idx = {read_col[5], read_row[4:2], read_col[4:2]};
            req.pal_idx  = read_col[4:0];
            unique case (op)
                vmwd_pkg::OP_READ_PIXEL: req.rd_kind = vmwd_pkg::RD_PIXEL;
                vmwd_pkg::OP_READ_NAME:
                    req.rd_kind = (read_row < vmwd_pkg::TBL_ROWS) ? vmwd_pkg::RD_NAME
                                                                  : vmwd_pkg::RD_NONE;
                vmwd_pkg::OP_READ_ATTR:
                    req.rd_kind = (read_row < vmwd_pkg::TBL_ROWS) ? vmwd_pkg::RD_ATTR
                                                                  : vmwd_pkg::RD_NONE;
                vmwd_pkg::OP_READ_PAL:   req.rd_kind = vmwd_pkg::RD_PAL;
                default:                 req.rd_kind = vmwd_pkg::RD_NONE;
            endcase
        end
    end

endmodule

// ===== rtl/core/vmwd_mem.sv =====
// ============================================================================
// vmwd_mem
// Video stores: two pattern planes, name table, attribute bytes and palette.
// Performs one registered access per executed beat and the clearing pass.
// ============================================================================
module vmwd_mem (
    input  logic               aclk,
    input  logic               aresetn,
    input  vmwd_pkg::mem_ctl_t ctl,
    input  vmwd_pkg::mem_req_t req,
    output logic [7:0]         rd_data
);

    localparam int PAT_DEPTH  = 1 << vmwd_pkg::PAT_IDX_W;
    localparam int NAME_DEPTH = 1 << vmwd_pkg::NAME_IDX_W;
    localparam int ATTR_DEPTH = 1 << vmwd_pkg::ATTR_IDX_W;

    logic [7:0] pat0_mem [PAT_DEPTH];
    logic [7:0] pat1_mem [PAT_DEPTH];
    logic [7:0] name_mem [NAME_DEPTH];
    logic [7:0] attr_mem [ATTR_DEPTH];
    logic [5:0] pal_reg  [vmwd_pkg::PAL_DEPTH];

    logic [7:0]          pat0_rd_reg;
    logic [7:0]          pat1_rd_reg;
    logic [7:0]          name_rd_reg;
    logic [7:0]          attr_rd_reg;
    logic [5:0]          pal_rd_reg;
    vmwd_pkg::rd_kind_t  rd_kind_reg;
    logic [2:0]          pix_col_reg;
    logic [1:0]          attr_quad_reg;

    logic [5:0] pal_raw;
    logic [5:0] pal_fix;
    logic [5:0] pal_bg;
    logic [2:0] pix_bit;

    // Clear or access the large stores
    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            pat0_mem[ctl.clr_idx] <= '0;
            pat1_mem[ctl.clr_idx] <= '0;
            name_mem[ctl.clr_idx[vmwd_pkg::NAME_IDX_W-1:0]] <= '0;
            attr_mem[ctl.clr_idx[vmwd_pkg::ATTR_IDX_W-1:0]] <= '0;
        end else if (ctl.exec) begin
            if (req.pat0_we) begin
                pat0_mem[req.pat_idx] <= req.wdata;
            end
            if (req.pat1_we) begin
                pat1_mem[req.pat_idx] <= req.wdata;
            end
            if (req.name_we) begin
                name_mem[req.name_idx] <= req.wdata;
            end
            if (req.attr_we) begin
                attr_mem[req.attr_idx] <= req.wdata;
            end
            pat0_rd_reg   <= pat0_mem[req.pat_idx];
            pat1_rd_reg   <= pat1_mem[req.pat_idx];
            name_rd_reg   <= name_mem[req.name_idx];
            attr_rd_reg   <= attr_mem[req.attr_idx];
            pal_rd_reg    <= pal_reg[req.pal_idx];
            pix_col_reg   <= req.pix_col;
            attr_quad_reg <= req.attr_quad;
        end
    end

    // Hold the kind of read for the result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_kind_reg <= vmwd_pkg::RD_NONE;
        end else if (ctl.exec) begin
            rd_kind_reg <= req.rd_kind;
        end
    end

    // Palette value: black becomes background black for shared entries
    assign pal_raw = req.wdata[5:0];
    assign pal_fix = (pal_raw == vmwd_pkg::PAL_BLACK) ? vmwd_pkg::PAL_BG_BLACK : pal_raw;
    assign pal_bg  = (req.pal_idx[3:0] == 4'd0) ? pal_fix : pal_reg[0];

    // Update palette; every fourth entry always mirrors entry zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vmwd_pkg::PAL_DEPTH; i++) begin
                pal_reg[i] <= vmwd_pkg::PAL_RESET;
            end
        end else if (ctl.exec && req.pal_we) begin
            if (req.pal_idx[1:0] != 2'b00) begin
                pal_reg[req.pal_idx] <= pal_raw;
            end else begin
                for (int i = 0; i < vmwd_pkg::PAL_DEPTH; i += 4) begin
                    pal_reg[i] <= pal_bg;
                end
            end
        end
    end

    // Select the read result; column 0 is the most significant plane bit
    assign pix_bit = ~pix_col_reg;

    always_comb begin
        unique case (rd_kind_reg)
            vmwd_pkg::RD_PIXEL: rd_data = {6'd0, pat1_rd_reg[pix_bit], pat0_rd_reg[pix_bit]};
            vmwd_pkg::RD_NAME:  rd_data = name_rd_reg;
            vmwd_pkg::RD_ATTR:  rd_data = {6'd0, attr_rd_reg[{attr_quad_reg, 1'b0} +: 2]};
            vmwd_pkg::RD_PAL:   rd_data = {2'd0, pal_rd_reg};
            default:            rd_data = 8'd0;
        endcase
    end

endmodule

// ===== rtl/core/vmwd_seq.sv =====
// ============================================================================
// vmwd_seq
// Sequencer: clearing pass after reset, input capture, execute beat with the
// video address update, and the result hold until it is taken.
// ============================================================================
module vmwd_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic [15:0]        s_address,
    input  logic [7:0]         s_data,
    input  logic [8:0]         s_read_tile,
    input  logic [4:0]         s_read_row,
    input  logic [5:0]         s_read_col,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_address_now,
    output vmwd_pkg::op_t      op,
    output logic [7:0]         data,
    output logic [8:0]         read_tile,
    output logic [4:0]         read_row,
    output logic [5:0]         read_col,
    output vmwd_pkg::mem_ctl_t ctl
);

    vmwd_pkg::state_t                state_reg, state_next;
    logic [vmwd_pkg::CLR_W-1:0]      clr_cnt_reg;
    logic [15:0]                     vaddr_reg;
    logic [15:0]                     vaddr_next;
    logic [15:0]                     step;
    vmwd_pkg::op_t                   op_reg;
    logic [15:0]                     addr_reg;
    logic [7:0]                      data_reg;
    logic [8:0]                      tile_reg;
    logic [4:0]                      row_reg;
    logic [5:0]                      col_reg;

    assign s_ready = (state_reg == vmwd_pkg::ST_IDLE);
    assign m_valid = (state_reg == vmwd_pkg::ST_RESP);

    // Advance the state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vmwd_pkg::ST_CLEAR:
                if (&clr_cnt_reg) begin
                    state_next = vmwd_pkg::ST_IDLE;
                end
            vmwd_pkg::ST_IDLE:
                if (s_valid) begin
                    state_next = vmwd_pkg::ST_EXEC;
                end
            vmwd_pkg::ST_EXEC: state_next = vmwd_pkg::ST_RESP;
            vmwd_pkg::ST_RESP:
                if (m_ready) begin
                    state_next = vmwd_pkg::ST_IDLE;
                end
            default: state_next = vmwd_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vmwd_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == vmwd_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= vmwd_pkg::op_t'(s_opcode);
            addr_reg <= s_address;
            data_reg <= s_data;
            tile_reg <= s_read_tile;
            row_reg  <= s_read_row;
            col_reg  <= s_read_col;
        end
    end

    // Step the video address by one column or one row, wrapping at 16 bits
    assign step = (op_reg == vmwd_pkg::OP_WRITE_STEP32) ? vmwd_pkg::STEP_ROW
                                                        : vmwd_pkg::STEP_COL;

    always_comb begin
        unique case (op_reg)
            vmwd_pkg::OP_LATCH:        vaddr_next = addr_reg;
            vmwd_pkg::OP_WRITE_STEP1,
            vmwd_pkg::OP_WRITE_STEP32: vaddr_next = vaddr_reg + step;
            default:                   vaddr_next = vaddr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vaddr_reg <= '0;
        end else if (state_reg == vmwd_pkg::ST_EXEC) begin
            vaddr_reg <= vaddr_next;
        end
    end

    assign m_address_now = vaddr_reg;
    assign op            = op_reg;
    assign data          = data_reg;
    assign read_tile     = tile_reg;
    assign read_row      = row_reg;
    assign read_col      = col_reg;

    assign ctl.clear   = (state_reg == vmwd_pkg::ST_CLEAR);
    assign ctl.clr_idx = clr_cnt_reg;
    assign ctl.exec    = (state_reg == vmwd_pkg::ST_EXEC);

endmodule

// ===== rtl/core/vmwd_checker.sv =====
// ============================================================================
// vmwd_checker
// Port-level checks of the video-memory write decoder, bound to the top.
// ============================================================================
module vmwd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_opcode,
    input logic [15:0] s_address,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_read_data,
    input logic [15:0] m_address_now
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_address_now))
        else $error("result changed while stalled");

    // Accept no beat while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid)
        else $error("beat accepted with result pending");

    // Drop ready after an accepted beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after accept");

    // A latch shows the new address in its result
    a_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == vmwd_pkg::OP_LATCH |=> ##1
            m_valid && m_address_now == $past(s_address, 2))
        else $error("latched address not shown");

    // A write returns zero read data
    a_wr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == vmwd_pkg::OP_WRITE_STEP1 ||
                               s_opcode == vmwd_pkg::OP_WRITE_STEP32) |=> ##1
            m_valid && m_read_data == 8'd0)
        else $error("write returned nonzero data");

endmodule

bind video_memory_write_decoder vmwd_checker u_vmwd_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Drives latch, write, read and no-op beats into the video-memory write
// decoder and checks every result against a shadow copy of the video stores
// and address register, with random idle gaps on the input side and random
// stalls on the result side.
// ============================================================================
module tb;

    localparam int          PIX_DEPTH      = 32768;
    localparam int          TBL_COLS       = 64;
    localparam int          TBL_DEPTH      = 1920;
    localparam int          ATTR_BASE      = 960;
    localparam logic [11:0] MIRROR_END     = 12'hF00;
    localparam logic [15:0] MIRROR_STEP    = 16'h1000;
    localparam logic [15:0] NAME_BASE      = 16'h2000;
    localparam logic [15:0] ATTR_ADDR      = 16'h23C0;
    localparam logic [15:0] TBL1_BIT       = 16'h0400;
    localparam logic [15:0] PAL_ADDR       = 16'h3F00;
    localparam int          ITEM_TARGET    = 1350;
    localparam int          PRESSURE_POINT = 600;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          CYCLE_LIMIT    = 1000000;

    typedef struct {
        vmwd_pkg::op_t op;
        logic [15:0]   addr;
        logic [7:0]    data;
        logic [8:0]    tile;
        logic [4:0]    row;
        logic [5:0]    col;
    } vram_beat_t;

    typedef struct {
        logic [7:0]  read_data;
        logic [15:0] address_now;
    } vram_reply_t;

    // Shadow of the video stores; holds the replies still owed by the block
    class vram_shadow;
        bit [15:0]   video_addr;
        bit [1:0]    pixels[PIX_DEPTH];
        bit [7:0]    names[TBL_DEPTH];
        bit [1:0]    attrs[TBL_DEPTH];
        bit [5:0]    palette[vmwd_pkg::PAL_DEPTH];
        vram_reply_t owed[$];
        int          errors;

        function void clear_state();
            video_addr = '0;
            foreach (pixels[i]) pixels[i] = '0;
            foreach (names[i]) names[i] = '0;
            foreach (attrs[i]) attrs[i] = '0;
            foreach (palette[i]) palette[i] = vmwd_pkg::PAL_RESET;
            owed.delete();
            errors = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void fill_block(int r, int c, bit [1:0] val);
            for (int rr = 0; rr < 2; rr++)
                for (int cc = 0; cc < 2; cc++)
                    attrs[((r + rr) * TBL_COLS + c + cc) % TBL_DEPTH] = val;
        endfunction

        function void store_byte(bit [15:0] a, bit [7:0] v);
            bit [15:0] eff;
            bit [4:0]  idx;
            bit [5:0]  val;
            int        base;
            int        tbl_ofs;
            int        k;
            int        r;
            int        c;
            eff = a;
            // fold the upper mirror of the tables back onto 0x2000
            if (eff[13:12] == 2'b11 && eff[11:0] < MIRROR_END)
                eff = eff - MIRROR_STEP;
            if (eff[13] == 1'b0) begin
                // pattern: one bitplane byte, leftmost pixel in bit 7
                base = int'(eff[12:4]) * 64 + int'(eff[2:0]) * 8;
                for (int x = 0; x < 8; x++)
                    pixels[base + x][eff[3]] = v[7 - x];
            end else if (eff[12] == 1'b0) begin
                tbl_ofs = eff[10] ? 32 : 0;
                r = int'(eff[9:5]);
                if (r < int'(vmwd_pkg::TBL_ROWS)) begin
                    names[r * TBL_COLS + int'(eff[4:0]) + tbl_ofs] = v;
                end else begin
                    // attribute byte: expand into a 4x4 block of entries
                    k = int'(eff[9:0]) - ATTR_BASE;
                    r = (k >> 3) * 4;
                    c = (k & 7) * 4 + tbl_ofs;
                    fill_block(r, c, v[1:0]);
                    fill_block(r, c + 2, v[3:2]);
                    if (r + 3 < int'(vmwd_pkg::TBL_ROWS)) begin
                        fill_block(r + 2, c, v[5:4]);
                        fill_block(r + 2, c + 2, v[7:6]);
                    end
                end
            end else begin
                idx = eff[4:0];
                val = v[5:0];
                palette[idx] = val;
                // background entries: black swap, pair mirror, share entry 0
                if (idx[1:0] == 2'b00) begin
                    if (val == vmwd_pkg::PAL_BLACK)
                        val = vmwd_pkg::PAL_BG_BLACK;
                    palette[{1'b0, idx[3:0]}] = val;
                    palette[{1'b1, idx[3:0]}] = val;
                    for (int i = 1; i < 8; i++)
                        palette[4 * i] = palette[0];
                end
            end
        endfunction

        function void note_beat(vram_beat_t b);
            vram_reply_t want;
            want.read_data = '0;
            case (b.op)
                vmwd_pkg::OP_LATCH: begin
                    video_addr = b.addr;
                end
                vmwd_pkg::OP_WRITE_STEP1, vmwd_pkg::OP_WRITE_STEP32: begin
                    store_byte(video_addr, b.data);
                    video_addr = video_addr + ((b.op == vmwd_pkg::OP_WRITE_STEP1)
                                               ? vmwd_pkg::STEP_COL : vmwd_pkg::STEP_ROW);
                end
                vmwd_pkg::OP_READ_PIXEL: begin
                    want.read_data = 8'(pixels[int'(b.tile) * 64 + int'(b.row[2:0]) * 8
                                               + int'(b.col[2:0])]);
                end
                vmwd_pkg::OP_READ_NAME: begin
                    if (b.row < vmwd_pkg::TBL_ROWS)
                        want.read_data = names[int'(b.row) * TBL_COLS + int'(b.col)];
                end
                vmwd_pkg::OP_READ_ATTR: begin
                    if (b.row < vmwd_pkg::TBL_ROWS)
                        want.read_data = 8'(attrs[int'(b.row) * TBL_COLS + int'(b.col)]);
                end
                vmwd_pkg::OP_READ_PAL: begin
                    want.read_data = 8'(palette[b.col[4:0]]);
                end
                default: ;
            endcase
            want.address_now = video_addr;
            owed.push_back(want);
        endfunction

        function void check_reply(logic [7:0] rd, logic [15:0] an);
            vram_reply_t want;
            if (owed.size() == 0) begin
                $display("%0t: result with nothing owed: read_data %02h address_now %04h",
                         $time, rd, an);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (rd !== want.read_data) begin
                $display("%0t: read_data expected %02h actual %02h",
                         $time, want.read_data, rd);
                errors++;
            end
            if (an !== want.address_now) begin
                $display("%0t: address_now expected %04h actual %04h",
                         $time, want.address_now, an);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode      = '0;
    logic [15:0] s_address     = '0;
    logic [7:0]  s_data        = '0;
    logic [8:0]  s_read_tile   = '0;
    logic [4:0]  s_read_row    = '0;
    logic [5:0]  s_read_col    = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_read_data;
    logic [15:0] m_address_now;

    vram_shadow  sb;
    int          beats_sent    = 0;
    int          replies_seen  = 0;
    int          sink_stall    = 0;
    int          cycle_count   = 0;
    bit          sender_calm   = 1'b0;
    bit          sink_calm     = 1'b0;

    video_memory_write_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_address     (s_address),
        .s_data        (s_data),
        .s_read_tile   (s_read_tile),
        .s_read_row    (s_read_row),
        .s_read_col    (s_read_col),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_address_now (m_address_now)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones, none during a calm stretch
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic vram_beat_t mk_beat(vmwd_pkg::op_t op, logic [15:0] addr,
                                           logic [7:0] data, logic [8:0] tile,
                                           logic [4:0] row, logic [5:0] col);
        vram_beat_t b;
        b.op   = op;
        b.addr = addr;
        b.data = data;
        b.tile = tile;
        b.row  = row;
        b.col  = col;
        return b;
    endfunction

    function automatic vram_beat_t random_beat(vmwd_pkg::op_t op);
        return mk_beat(op, 16'($urandom), 8'($urandom), 9'($urandom),
                       5'($urandom), 6'($urandom));
    endfunction

    // Latch target, weighted toward each store and its mirrors
    function automatic logic [15:0] pick_target();
        logic [15:0] hi;
        logic [15:0] mirror;
        hi     = {2'($urandom_range(0, 3)), 14'd0};
        mirror = $urandom_range(0, 1) ? MIRROR_STEP : 16'h0000;
        case ($urandom_range(0, 4))
            0:       return hi | 16'($urandom_range(0, 16'h1FFF));
            1:       return hi | NAME_BASE | mirror | 16'($urandom_range(0, 16'h0FFF));
            2:       return hi | ATTR_ADDR | mirror | ($urandom_range(0, 1) ? TBL1_BIT : 16'h0)
                            | 16'($urandom_range(0, 63));
            3:       return hi | PAL_ADDR | 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Read aimed at the pattern or table entries a burst from this base wrote
    function automatic vram_beat_t aimed_read(logic [15:0] base);
        vram_beat_t b;
        logic [15:0] eff;
        int          k;
        eff = base;
        if (eff[13:12] == 2'b11 && eff[11:0] < MIRROR_END)
            eff = eff - MIRROR_STEP;
        b = random_beat(vmwd_pkg::OP_READ_PAL);
        if (eff[13] == 1'b0) begin
            b.op       = vmwd_pkg::OP_READ_PIXEL;
            b.tile     = eff[12:4];
            b.row[2:0] = eff[2:0];
        end else if (eff[12] == 1'b0) begin
            if (eff[9:5] < vmwd_pkg::TBL_ROWS || $urandom_range(0, 3) == 0) begin
                b.op  = $urandom_range(0, 1) ? vmwd_pkg::OP_READ_NAME : vmwd_pkg::OP_READ_ATTR;
                b.row = eff[9:5];
                b.col = {eff[10], eff[4:0]} + 6'($urandom_range(0, 3));
            end else begin
                k     = int'(eff[9:0]) - ATTR_BASE;
                b.op  = vmwd_pkg::OP_READ_ATTR;
                b.row = 5'((k >> 3) * 4 + $urandom_range(0, 3));
                b.col = {eff[10], 5'd0} + 6'((k & 7) * 4 + $urandom_range(0, 3));
            end
        end
        return b;
    endfunction

    // Present one beat after a random gap and hold it until accepted
    task automatic send_beat(vram_beat_t b);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= b.op;
        s_address   <= b.addr;
        s_data      <= b.data;
        s_read_tile <= b.tile;
        s_read_row  <= b.row;
        s_read_col  <= b.col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_beat(b);
        beats_sent++;
        if (beats_sent % 90 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Latch, a run of writes, then reads, mostly of what was written
    task automatic run_burst();
        vram_beat_t    b;
        logic [15:0]   base;
        vmwd_pkg::op_t step_op;
        int            n_wr;
        int            n_rd;
        base    = pick_target();
        step_op = $urandom_range(0, 1) ? vmwd_pkg::OP_WRITE_STEP1 : vmwd_pkg::OP_WRITE_STEP32;
        n_wr    = $urandom_range(1, 8);
        n_rd    = $urandom_range(1, 4);
        b       = random_beat(vmwd_pkg::OP_LATCH);
        b.addr  = base;
        send_beat(b);
        repeat (n_wr) begin
            b = random_beat(step_op);
            if ($urandom_range(0, 5) == 0)
                b.op = (step_op == vmwd_pkg::OP_WRITE_STEP1) ? vmwd_pkg::OP_WRITE_STEP32
                                                             : vmwd_pkg::OP_WRITE_STEP1;
            if ($urandom_range(0, 7) == 0)
                b.data = {2'($urandom_range(0, 3)), vmwd_pkg::PAL_BLACK};
            send_beat(b);
        end
        repeat (n_rd) begin
            if ($urandom_range(0, 3) == 0)
                b = random_beat(vmwd_pkg::op_t'($urandom_range(3, 6)));
            else
                b = aimed_read(base);
            send_beat(b);
        end
    endtask

    // Result side: check each beat, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_reply(m_read_data, m_address_now);
                replies_seen++;
                if (replies_seen % 100 == 0)
                    sink_calm = ($urandom_range(0, 3) == 0);
                sink_stall = pick_gap(sink_calm);
            end else if (sink_stall > 0) begin
                sink_stall--;
            end else if (!sink_calm && $urandom_range(0, 19) == 0) begin
                sink_stall = $urandom_range(1, 6);
            end
            m_ready <= (sink_stall == 0);
        end
    end

    // Cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        vram_beat_t opening_beats[$];
        bit         drained_once;
        drained_once = 1'b0;
        sb = new();
        sb.clear_state();

        // Corner cases: both pattern planes, last tile, last name row,
        // attribute rows incl. the clipped bottom row, table mirror,
        // background black swap, palette pairs, 16-bit wrap, no-op
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_PAL,
                                        16'h0000, 8'h00, 9'd0,   5'd0,  6'd63));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_LATCH,
                                        16'h0000, 8'h00, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP1,
                                        16'h0000, 8'hA5, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_LATCH,
                                        16'h0008, 8'h00, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP32,
                                        16'h0000, 8'hFF, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_PIXEL,
                                        16'h0000, 8'h00, 9'd0,   5'd8,  6'd15));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_LATCH,
                                        16'hDFFF, 8'h00, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP1,
                                        16'h0000, 8'h81, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_PIXEL,
                                        16'h0000, 8'h00, 9'd511, 5'd31, 6'd63));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_LATCH,
                                        16'h23BF, 8'h00, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP1,
                                        16'h0000, 8'h7E, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP1,
                                        16'h0000, 8'hE4, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_LATCH,
                                        16'h27F8, 8'h00, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP32,
                                        16'h0000, 8'hFF, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_NAME,
                                        16'h0000, 8'h00, 9'd0,   5'd29, 6'd31));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_NAME,
                                        16'h0000, 8'h00, 9'd0,   5'd30, 6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_ATTR,
                                        16'h0000, 8'h00, 9'd0,   5'd29, 6'd33));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_ATTR,
                                        16'h0000, 8'h00, 9'd0,   5'd31, 6'd63));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_LATCH,
                                        16'h3EFF, 8'h00, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP1,
                                        16'h0000, 8'h55, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_NAME,
                                        16'h0000, 8'h00, 9'd0,   5'd23, 6'd63));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_LATCH,
                                        16'h3F00, 8'h00, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP1,
                                        16'h0000, 8'h0F, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_READ_PAL,
                                        16'h0000, 8'h00, 9'd0,   5'd0,  6'd16));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_LATCH,
                                        16'hFFFF, 8'h00, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_WRITE_STEP32,
                                        16'h0000, 8'hCF, 9'd0,   5'd0,  6'd0));
        opening_beats.push_back(mk_beat(vmwd_pkg::OP_NOP,
                                        16'hFFFF, 8'hFF, 9'd511, 5'd31, 6'd63));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_beats[i])
            send_beat(opening_beats[i]);

        // Random bursts with some noise beats mixed in
        while (beats_sent < ITEM_TARGET) begin
            if (!drained_once && beats_sent >= PRESSURE_POINT) begin
                wait_drained();
                drained_once = 1'b1;
            end
            if ($urandom_range(0, 99) < 80)
                run_burst();
            else
                send_beat(random_beat(vmwd_pkg::op_t'($urandom_range(0, 7))));
        end

        // Drain and let any stray result show up
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
